>>> rtl/core/mvm_pkg.sv
// Shared types and constants for the matrix-vector multiply core.
// No dependencies; imported by every module under rtl/core.
package mvm_pkg;

    localparam int MAX_ORDER   = 1024;
    localparam int ADDR_W      = $clog2(MAX_ORDER);
    localparam int SIZE_W      = 11;
    localparam int N_W         = (SIZE_W > ADDR_W + 1) ? SIZE_W : ADDR_W + 1;
    localparam int VAL_W       = 16;
    localparam int PROD_W      = 2 * VAL_W;
    localparam int ACC_W       = 48;
    localparam int ROW_W       = 10;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = FIFO_PTR_W + 1;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_MAC    = 1'b1;

    typedef struct packed {
        logic                    op;
        logic signed [VAL_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [ROW_W-1:0]        row_index;
        logic signed [ACC_W-1:0] dot_product;
        logic                    last_row;
    } t_out_item;

    // classified request handed from front to back
    typedef struct packed {
        logic                    op;
        logic signed [VAL_W-1:0] value;
        logic [ADDR_W-1:0]       addr;
        logic                    row_end;
        logic                    last_row;
        logic [ROW_W-1:0]        row_index;
    } t_cmd;

    typedef struct packed {
        logic                  full;
        logic                  valid;
        logic [FIFO_CNT_W-1:0] count;
    } t_fifo_status;

endpackage

>>> rtl/core/mvm_front.sv
// Front end: size register, load/row/column counters, request classification.
// Depends on mvm_pkg.
module mvm_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [mvm_pkg::SIZE_W-1:0] i_cfg_data,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  mvm_pkg::t_in_item i_in_data,
    input  logic            i_full,
    output logic            o_push,
    output mvm_pkg::t_cmd   o_cmd
);
    import mvm_pkg::*;

    logic [SIZE_W-1:0] r_size;
    logic [ADDR_W-1:0] r_load_idx, n_load_idx;
    logic [ADDR_W-1:0] r_row, n_row;
    logic [ADDR_W-1:0] r_col, n_col;
    logic [N_W-1:0]    order;
    logic              row_end;
    logic              last_row;
    logic              load_wrap;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !i_full;
    assign o_push      = i_in_valid && !i_full;

    always_comb begin
        if (r_size == '0) begin
            order = N_W'(1);
        end else if (N_W'(r_size) > N_W'(MAX_ORDER)) begin
            order = N_W'(MAX_ORDER);
        end else begin
            order = N_W'(r_size);
        end
    end

    assign row_end   = (N_W'(r_col) + N_W'(1)) >= order;
    assign last_row  = (N_W'(r_row) + N_W'(1)) >= order;
    assign load_wrap = (N_W'(r_load_idx) + N_W'(1)) >= order;

    always_comb begin
        o_cmd.op        = i_in_data.op;
        o_cmd.value     = i_in_data.value;
        o_cmd.addr      = (i_in_data.op == OP_LOAD) ? r_load_idx : r_col;
        o_cmd.row_end   = row_end;
        o_cmd.last_row  = last_row;
        o_cmd.row_index = ROW_W'(r_row);

        n_load_idx = r_load_idx;
        n_row      = r_row;
        n_col      = r_col;
        if (o_push) begin
            if (i_in_data.op == OP_LOAD) begin
                n_load_idx = load_wrap ? '0 : r_load_idx + 1'b1;
                n_row      = '0;
                n_col      = '0;
            end else if (row_end) begin
                n_col = '0;
                n_row = last_row ? '0 : r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size     <= SIZE_W'(MAX_ORDER);
            r_load_idx <= '0;
            r_row      <= '0;
            r_col      <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_size <= i_cfg_data;
            end
            r_load_idx <= n_load_idx;
            r_row      <= n_row;
            r_col      <= n_col;
        end
    end

endmodule

>>> rtl/core/mvm_fifo.sv
// Short request queue between front and back ends.
// Depends on mvm_pkg.
module mvm_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  mvm_pkg::t_cmd        i_cmd,
    input  logic                 i_pop,
    output mvm_pkg::t_cmd        o_cmd,
    output mvm_pkg::t_fifo_status o_status
);
    import mvm_pkg::*;

    t_cmd                  r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count, n_count;

    assign o_cmd           = r_mem[r_rd_ptr];
    assign o_status.full   = (r_count == FIFO_CNT_W'(FIFO_DEPTH));
    assign o_status.valid  = (r_count != '0);
    assign o_status.count  = r_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

endmodule

>>> rtl/core/mvm_back.sv
// Back end: vector memory, multiplier, accumulator and output register.
// Depends on mvm_pkg.
module mvm_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  mvm_pkg::t_cmd     i_cmd,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output mvm_pkg::t_out_item o_out_data
);
    import mvm_pkg::*;

    logic [VAL_W-1:0]         r_vec_mem [MAX_ORDER];
    logic                     r_s1_valid;
    t_cmd                     r_s1_cmd;
    logic signed [VAL_W-1:0]  r_rd_data;
    logic                     r_s2_valid;
    t_cmd                     r_s2_cmd;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  sum;
    logic                     r_out_valid;
    t_out_item                r_out;
    logic                     adv;

    assign adv         = !r_out_valid || i_out_ready;
    assign o_pop       = adv && i_cmd_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign sum         = r_acc + ACC_W'(r_prod);

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            if (i_cmd.op == OP_LOAD) begin
                r_vec_mem[i_cmd.addr] <= i_cmd.value;
            end else begin
                r_rd_data <= r_vec_mem[i_cmd.addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_cmd <= i_cmd;
            r_s2_cmd <= r_s1_cmd;
            r_prod   <= r_s1_cmd.value * r_rd_data;
            if (r_s2_valid && r_s2_cmd.op == OP_MAC && r_s2_cmd.row_end) begin
                r_out.row_index   <= r_s2_cmd.row_index;
                r_out.dot_product <= sum;
                r_out.last_row    <= r_s2_cmd.last_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_acc       <= '0;
        end else if (adv) begin
            r_s1_valid  <= i_cmd_valid;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid && r_s2_cmd.op == OP_MAC && r_s2_cmd.row_end;
            if (r_s2_valid) begin
                if (r_s2_cmd.op == OP_LOAD || r_s2_cmd.row_end) begin
                    r_acc <= '0;
                end else begin
                    r_acc <= sum;
                end
            end
        end
    end

endmodule

>>> rtl/core/matrix_vector_multiply_core.sv
// Top level of the matrix-vector multiply core.
// Depends on mvm_pkg, mvm_front, mvm_fifo and mvm_back.
//
// Streams a vector (op 0) and then a matrix in row-major order (op 1), all
// signed Q8.8, and returns one signed Q32.16 dot product per matrix row with
// its row index and a last-row flag. One request is taken every clock cycle
// while the queue is not full; the front end classifies it against the load,
// row and column counters and queues it, and the back end, unless a stalled
// output holds it, runs one vector-memory read and one multiply-accumulate
// per cycle. A row result is registered after the row's final element has
// passed the read and multiply stages. The four-entry queue lets the front
// keep taking requests until it fills. The size register is written through
// its own channel and is always ready; write it only while the core is idle.
module matrix_vector_multiply_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [mvm_pkg::SIZE_W-1:0] i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  mvm_pkg::t_in_item          i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output mvm_pkg::t_out_item         o_out_data
);
    import mvm_pkg::*;

    logic         push;
    logic         pop;
    t_cmd         front_cmd;
    t_cmd         queue_cmd;
    t_fifo_status fifo_st;

    mvm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_full      (fifo_st.full),
        .o_push      (push),
        .o_cmd       (front_cmd)
    );

    mvm_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (front_cmd),
        .i_pop    (pop),
        .o_cmd    (queue_cmd),
        .o_status (fifo_st)
    );

    mvm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (fifo_st.valid),
        .i_cmd       (queue_cmd),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fifo_st.count <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("queue count above depth");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> fifo_st.valid)
        else $error("pop from empty queue");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (fifo_st.count == $past(fifo_st.count) + 1'b1))
        else $error("queue count lost a push");

    a_stall_holds_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !pop)
        else $error("back end popped while output stalled");

endmodule
